### design/cst_pkg.sv
package cst_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int KEY_WIDTH = 64;
	localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_DISCONNECT = 2'd1;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_CAPACITY = 3'd2;
	localparam logic [2:0] ST_UNKNOWN = 3'd3;
	localparam logic [2:0] ST_DENIED = 3'd4;

	localparam logic [31:0] FIRST_IDENT = 32'd1;

	typedef struct packed {
		logic [1:0] action;
		logic well_formed;
		logic [31:0] client_id;
		logic [63:0] caller_key;
		logic [31:0] request_tag;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] result_id;
		logic [31:0] result_tag;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

### design/client_session_table_unit.sv
// Channel   Ports                     Handshake
// request   start, busy, request      taken when start is high and busy is low
// response  done, response            valid for the one cycle done is high
//
// For each word the accept edge stores the word with the slot search over the
// 16 active bits and identifiers, and the next edge checks the key, updates the
// table and registers the response; done is registered at that same edge, and a
// new word may already be accepted while done is high. Reset clears the active
// bits and sets the identifier counter to one. The receiver cannot stall.
module client_session_table_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input cst_pkg::req_t request,
	output logic done,
	output cst_pkg::rsp_t response
);

	cst_pkg::cmd_t cmd;

	cst_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.done(done),
		.cmd(cmd)
	);

	cst_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.request(request),
		.response(response)
	);

endmodule

### design/cst_ctrl.sv
module cst_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	output cst_pkg::cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && start;
		cmd.exec = (state_q == S_EXEC);
		unique case (state_q)
			S_IDLE: state_d = start ? S_EXEC : S_IDLE;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= cmd.exec;
		end
	end

	assign busy = (state_q == S_EXEC);
	assign done = done_q;

endmodule

### design/cst_datapath.sv
module cst_datapath (
	input logic clk,
	input logic arst_n,
	input cst_pkg::cmd_t cmd,
	input cst_pkg::req_t request,
	output cst_pkg::rsp_t response
);

	logic [cst_pkg::SLOT_COUNT-1:0] active_q;
	logic [31:0] ident_q [cst_pkg::SLOT_COUNT];
	logic [cst_pkg::KEY_WIDTH-1:0] key_q [cst_pkg::SLOT_COUNT];
	logic [31:0] next_q;

	cst_pkg::req_t req_q;
	logic hit_q;
	logic [cst_pkg::SLOT_IDX_W-1:0] hit_idx_q;
	logic free_q;
	logic [cst_pkg::SLOT_IDX_W-1:0] free_idx_q;
	cst_pkg::rsp_t rsp_q;

	logic [cst_pkg::SLOT_COUNT-1:0] match_vec;
	logic hit_d;
	logic [cst_pkg::SLOT_IDX_W-1:0] hit_idx_d;
	logic free_d;
	logic [cst_pkg::SLOT_IDX_W-1:0] free_idx_d;

	logic [cst_pkg::KEY_WIDTH-1:0] req_key;
	logic key_eq;
	logic do_alloc;
	logic do_clear;
	cst_pkg::rsp_t rsp_d;

	// The table only changes in the execute cycle, so the search runs on the
	// word at the port and its result is held with the word.
	always_comb begin
		hit_d = 1'b0;
		hit_idx_d = '0;
		free_d = 1'b0;
		free_idx_d = '0;
		for (int i = cst_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			match_vec[i] = active_q[i] && (ident_q[i] == request.client_id);
			if (match_vec[i]) begin
				hit_d = 1'b1;
				hit_idx_d = cst_pkg::SLOT_IDX_W'(i);
			end
			if (!active_q[i]) begin
				free_d = 1'b1;
				free_idx_d = cst_pkg::SLOT_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
			hit_q <= hit_d;
			hit_idx_q <= hit_idx_d;
			free_q <= free_d;
			free_idx_q <= free_idx_d;
		end
	end

	always_comb begin
		req_key = req_q.caller_key[cst_pkg::KEY_WIDTH-1:0];
		key_eq = (key_q[hit_idx_q] == req_key);
		do_alloc = 1'b0;
		do_clear = 1'b0;
		rsp_d.status = cst_pkg::ST_OK;
		rsp_d.result_id = req_q.client_id;
		rsp_d.result_tag = req_q.request_tag;
		priority if (!req_q.well_formed) begin
			rsp_d.status = cst_pkg::ST_INVALID;
			rsp_d.result_id = '0;
			rsp_d.result_tag = '0;
		end else if (req_q.action == cst_pkg::ACT_REGISTER) begin
			if (!free_q || (next_q == '0)) begin
				rsp_d.status = cst_pkg::ST_CAPACITY;
				rsp_d.result_id = '0;
			end else begin
				do_alloc = 1'b1;
				rsp_d.result_id = next_q;
			end
		end else if (!hit_q) begin
			rsp_d.status = cst_pkg::ST_UNKNOWN;
		end else if (!key_eq) begin
			rsp_d.status = cst_pkg::ST_DENIED;
		end else begin
			do_clear = (req_q.action == cst_pkg::ACT_DISCONNECT);
		end
	end

	// Of the table, only the active bits need a reset: an inactive slot is never
	// matched and its key never decides a response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			next_q <= cst_pkg::FIRST_IDENT;
		end else if (cmd.exec) begin
			if (do_alloc) begin
				active_q[free_idx_q] <= 1'b1;
				next_q <= next_q + 32'd1;
			end
			if (do_clear) begin
				active_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (do_alloc) begin
				ident_q[free_idx_q] <= next_q;
				key_q[free_idx_q] <= req_key;
			end
			if (do_clear) begin
				ident_q[hit_idx_q] <= '0;
				key_q[hit_idx_q] <= '0;
			end
			rsp_q <= rsp_d;
		end
	end

	assign response = rsp_q;

`ifndef SYNTHESIS
	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $past(cmd.load))
		else $error("execute cycle without a loaded word");
	a_counter_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.exec |=> $stable(next_q))
		else $error("identifier counter moved outside an execute cycle");
	a_unique_ident: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("two active slots hold the same identifier");
	a_no_alloc_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && do_alloc) |-> !active_q[free_idx_q])
		else $error("allocation into an active slot");
`endif

endmodule

### tb/client_session_table_unit_tb.sv
module client_session_table_unit_tb;

	localparam logic [1:0] ACT_OTHER = 2'd2;
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int RANDOM_WORDS = 550;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cst_pkg::req_t request = '0;
	logic done;
	cst_pkg::rsp_t response;

	client_session_table_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.response(response)
	);

	always #4 clk = ~clk;

	// Predicted copy of the session table.
	logic sess_active [cst_pkg::SLOT_COUNT];
	logic [31:0] sess_ident [cst_pkg::SLOT_COUNT];
	logic [63:0] sess_key [cst_pkg::SLOT_COUNT];
	logic [31:0] ident_counter;

	cst_pkg::req_t word_q [$];
	cst_pkg::rsp_t answer_q [$];
	int mismatch_count = 0;
	int words_sent = 0;
	int word_total = 1;
	int quiet_cycles = 0;
	logic drive_en = 1'b0;
	logic word_taken = 1'b0;

	// Sessions believed open, used only to steer the stimulus.
	logic [31:0] open_id [$];
	logic [63:0] open_key [$];
	logic [31:0] issue_next = 32'd1;

	initial begin
		for (int i = 0; i < cst_pkg::SLOT_COUNT; i++) begin
			sess_active[i] = 1'b0;
			sess_ident[i] = '0;
			sess_key[i] = '0;
		end
		ident_counter = cst_pkg::FIRST_IDENT;
	end

	task automatic session_apply(input cst_pkg::req_t w, output cst_pkg::rsp_t a);
		int hit;
		int vacant;
		hit = -1;
		vacant = -1;
		a = '0;
		if (!w.well_formed) begin
			a.status = cst_pkg::ST_INVALID;
		end else begin
			a.result_tag = w.request_tag;
			if (w.action == cst_pkg::ACT_REGISTER) begin
				for (int i = cst_pkg::SLOT_COUNT - 1; i >= 0; i--)
					if (!sess_active[i])
						vacant = i;
				if (vacant < 0 || ident_counter == '0) begin
					a.status = cst_pkg::ST_CAPACITY;
				end else begin
					sess_active[vacant] = 1'b1;
					sess_ident[vacant] = ident_counter;
					sess_key[vacant] = w.caller_key;
					a.result_id = ident_counter;
					a.status = cst_pkg::ST_OK;
					ident_counter = ident_counter + 32'd1;
				end
			end else begin
				a.result_id = w.client_id;
				for (int i = cst_pkg::SLOT_COUNT - 1; i >= 0; i--)
					if (sess_active[i] && sess_ident[i] == w.client_id)
						hit = i;
				if (hit < 0) begin
					a.status = cst_pkg::ST_UNKNOWN;
				end else if (sess_key[hit] != w.caller_key) begin
					a.status = cst_pkg::ST_DENIED;
				end else begin
					a.status = cst_pkg::ST_OK;
					// Only a disconnect frees the slot; other requests just pass.
					if (w.action == cst_pkg::ACT_DISCONNECT) begin
						sess_active[hit] = 1'b0;
						sess_ident[hit] = '0;
						sess_key[hit] = '0;
					end
				end
			end
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	task automatic add_word(input logic [1:0] act, input logic wf, input logic [31:0] id,
			input logic [63:0] key, input logic [31:0] tag);
		cst_pkg::req_t w;
		w.action = act;
		w.well_formed = wf;
		w.client_id = id;
		w.caller_key = key;
		w.request_tag = tag;
		word_q.push_back(w);
		if (wf && act == cst_pkg::ACT_REGISTER && open_id.size() < cst_pkg::SLOT_COUNT) begin
			open_id.push_back(issue_next);
			open_key.push_back(key);
			issue_next++;
		end else if (wf && act == cst_pkg::ACT_DISCONNECT) begin
			for (int k = 0; k < open_id.size(); k++)
				if (open_id[k] == id && open_key[k] == key) begin
					open_id.delete(k);
					open_key.delete(k);
					break;
				end
		end
	endtask

	function automatic logic [63:0] pick_key();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		else
			return {$urandom, $urandom};
	endfunction

	// The phase follows progress through the word list: none, heavy, none, light.
	always @(negedge clk) begin : drv
		int gap_pct;
		unique case ((words_sent * 4) / word_total)
			1: gap_pct = 88;
			3: gap_pct = 16;
			default: gap_pct = 0;
		endcase
		if (drive_en && (!start || word_taken)) begin
			if (word_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
				request <= word_q.pop_front();
				start <= 1'b1;
				words_sent <= words_sent + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : mon
		cst_pkg::rsp_t want;
		cst_pkg::rsp_t fresh;
		if (!arst_n) begin
			word_taken <= 1'b0;
		end else begin
			word_taken <= start && !busy;
			if (done === 1'b1) begin
				if (answer_q.size() == 0) begin
					$display("%0t: unexpected response expected none actual %h", $time, response);
					mismatch_count++;
				end else begin
					want = answer_q.pop_front();
					check_field("status", 32'(want.status), 32'(response.status));
					check_field("result_id", want.result_id, response.result_id);
					check_field("result_tag", want.result_tag, response.result_tag);
				end
			end
			if (start && !busy) begin
				session_apply(request, fresh);
				answer_q.push_back(fresh);
			end
			if ((start && !busy) || done === 1'b1) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stim
		int r;
		int pick;
		// Rejected headers with identifier, key and tag at their top value.
		add_word(ACT_SPARE, 1'b0, '1, '1, '1);
		add_word(cst_pkg::ACT_REGISTER, 1'b0, '1, '1, '1);
		// Lookup of identifier zero on an empty table.
		add_word(ACT_OTHER, 1'b1, '0, '0, '0);
		add_word(cst_pkg::ACT_REGISTER, 1'b1, '1, '0, 32'h0000_0001);
		add_word(cst_pkg::ACT_REGISTER, 1'b1, '0, '1, 32'hffff_fffe);
		add_word(ACT_OTHER, 1'b1, 32'd1, '0, $urandom);
		add_word(ACT_OTHER, 1'b1, 32'd2, '0, $urandom);
		// Action three behaves as an ordinary owned request.
		add_word(ACT_SPARE, 1'b1, 32'd2, '1, $urandom);
		add_word(cst_pkg::ACT_DISCONNECT, 1'b1, 32'd1, 64'h8000_0000_0000_0000, $urandom);
		add_word(cst_pkg::ACT_DISCONNECT, 1'b1, 32'd1, '0, $urandom);
		add_word(ACT_OTHER, 1'b1, 32'd1, '0, $urandom);
		// A rejected header must not close the session it names.
		add_word(cst_pkg::ACT_DISCONNECT, 1'b0, 32'd2, '1, $urandom);
		while (open_id.size() < cst_pkg::SLOT_COUNT)
			add_word(cst_pkg::ACT_REGISTER, 1'b1, $urandom, pick_key(), $urandom);
		// Full table answers with a capacity error.
		add_word(cst_pkg::ACT_REGISTER, 1'b1, $urandom, pick_key(), $urandom);
		add_word(cst_pkg::ACT_DISCONNECT, 1'b1, 32'd2, '1, $urandom);
		add_word(cst_pkg::ACT_REGISTER, 1'b1, $urandom, pick_key(), $urandom);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			r = $urandom_range(99);
			pick = (open_id.size() > 0) ? $urandom_range(open_id.size() - 1) : 0;
			if (r < 8)
				add_word(2'($urandom_range(3)), 1'b0, $urandom, pick_key(), $urandom);
			else if (r < 35 || open_id.size() == 0)
				add_word(cst_pkg::ACT_REGISTER, 1'b1, $urandom, pick_key(), $urandom);
			else if (r < 58)
				add_word($urandom_range(1) ? ACT_OTHER : ACT_SPARE, 1'b1, open_id[pick],
					open_key[pick], $urandom);
			else if (r < 72)
				add_word(cst_pkg::ACT_DISCONNECT, 1'b1, open_id[pick], open_key[pick],
					$urandom);
			else if (r < 82)
				add_word(2'($urandom_range(1, 3)), 1'b1, open_id[pick],
					open_key[pick] ^ (64'd1 << $urandom_range(63)), $urandom);
			else if (r < 90)
				add_word(2'($urandom_range(1, 3)), 1'b1, $urandom_range(issue_next + 3),
					pick_key(), $urandom);
			else
				add_word(2'($urandom_range(3)), 1'b1, $urandom, pick_key(), $urandom);
		end
		word_total = word_q.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drive_en = 1'b1;

		while (word_q.size() != 0 || start)
			@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### client_session_table_unit.f
design/cst_pkg.sv
design/cst_ctrl.sv
design/cst_datapath.sv
design/client_session_table_unit.sv
tb/client_session_table_unit_tb.sv
